// ===== rtl/core/cfot_pkg.sv =====
// ----------------------------------------------------------------------------
// cfot_pkg
// Types and constants shared by the change-filtered observation table.
// ----------------------------------------------------------------------------
package cfot_pkg;

  localparam int Entries   = 8;
  localparam int IdxW      = $clog2(Entries);
  localparam int KeyW      = 64;
  localparam int WordW     = 64;
  localparam int SnapWords = 4;
  localparam int FlagW     = 3;
  localparam int SlotW     = 3;
  localparam int KindW     = 2;

  typedef enum logic [KindW-1:0] {
    KindHit     = 2'd0,
    KindFree    = 2'd1,
    KindReplace = 2'd2
  } cfot_kind_e;

  typedef logic [SnapWords-1:0][WordW-1:0] cfot_snap_t;

  typedef struct packed {
    logic [KeyW-1:0]  token;
    logic             found;
    logic             snapshot_valid;
    logic [WordW-1:0] snap_word0;
    logic [WordW-1:0] snap_word1;
    logic [WordW-1:0] snap_word2;
    logic [WordW-1:0] snap_word3;
    logic [FlagW-1:0] snap_flags;
  } cfot_req_t;

  typedef struct packed {
    logic             report_lookup;
    logic             report_state;
    logic [SlotW-1:0] slot;
    cfot_kind_e       slot_kind;
  } cfot_rsp_t;

endpackage

// ===== rtl/core/cfot_if.sv =====
// ----------------------------------------------------------------------------
// cfot_if
// Request and result channels of the change-filtered observation table.
// ----------------------------------------------------------------------------
interface cfot_req_if;
  import cfot_pkg::*;

  logic             valid;
  logic             ready;
  logic [KeyW-1:0]  token;
  logic             found;
  logic             snapshot_valid;
  logic [WordW-1:0] snap_word0;
  logic [WordW-1:0] snap_word1;
  logic [WordW-1:0] snap_word2;
  logic [WordW-1:0] snap_word3;
  logic [FlagW-1:0] snap_flags;

  modport source (
    output valid, token, found, snapshot_valid,
    output snap_word0, snap_word1, snap_word2, snap_word3, snap_flags,
    input  ready
  );

  modport sink (
    input  valid, token, found, snapshot_valid,
    input  snap_word0, snap_word1, snap_word2, snap_word3, snap_flags,
    output ready
  );
endinterface

interface cfot_rsp_if;
  import cfot_pkg::*;

  logic             valid;
  logic             ready;
  logic             report_lookup;
  logic             report_state;
  logic [SlotW-1:0] slot;
  cfot_kind_e       slot_kind;

  modport source (
    output valid, report_lookup, report_state, slot, slot_kind,
    input  ready
  );

  modport sink (
    input  valid, report_lookup, report_state, slot, slot_kind,
    output ready
  );
endinterface

// ===== rtl/core/change_filtered_observation_table_top.sv =====
// ----------------------------------------------------------------------------
// change_filtered_observation_table_top
// Fully associative observation table with round-robin replacement that
// reports lookup and snapshot changes per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   token, found, snapshot_valid, snap_word0..3, snap_flags
//  rsp_o    out  valid/ready   report_lookup, report_state, slot, slot_kind
//
//  One request per cycle sustained while rsp_o is not stalled; an accepted
//  request is held in the request register, then its result in the result register.
//  The request register, the table compare/update and the result register
//  form the path; the table updates in the cycle the request moves on.
//  Reset clears entry occupancy, snapshot valid flags and the cursor at once.
//  A stalled result holds the request register, then req_i.ready drops.
// ----------------------------------------------------------------------------
module change_filtered_observation_table_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfot_req_if.sink   req_i,
  cfot_rsp_if.source rsp_o
);
  import cfot_pkg::*;

  cfot_req_t in_req;
  cfot_req_t stage_req;
  cfot_rsp_t tbl_rsp;
  cfot_rsp_t out_rsp;
  logic      stage_vld;
  logic      out_free;
  logic      adv;

  assign in_req.token          = req_i.token;
  assign in_req.found          = req_i.found;
  assign in_req.snapshot_valid = req_i.snapshot_valid;
  assign in_req.snap_word0     = req_i.snap_word0;
  assign in_req.snap_word1     = req_i.snap_word1;
  assign in_req.snap_word2     = req_i.snap_word2;
  assign in_req.snap_word3     = req_i.snap_word3;
  assign in_req.snap_flags     = req_i.snap_flags;

  assign adv = stage_vld && out_free;

  cfot_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .req_i   (in_req),
    .adv_i   (adv),
    .valid_o (stage_vld),
    .req_o   (stage_req)
  );

  cfot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (stage_req),
    .rsp_o  (tbl_rsp)
  );

  cfot_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .rsp_i   (tbl_rsp),
    .free_o  (out_free),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .rsp_o   (out_rsp)
  );

  assign rsp_o.report_lookup = out_rsp.report_lookup;
  assign rsp_o.report_state  = out_rsp.report_state;
  assign rsp_o.slot          = out_rsp.slot;
  assign rsp_o.slot_kind     = out_rsp.slot_kind;

endmodule

// ===== rtl/core/cfot_in_stage.sv =====
// ----------------------------------------------------------------------------
// cfot_in_stage
// Request register in front of the table lookup.
// ----------------------------------------------------------------------------
module cfot_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cfot_pkg::cfot_req_t req_i,
  input  logic                adv_i,
  output logic                valid_o,
  output cfot_pkg::cfot_req_t req_o
);
  import cfot_pkg::*;

  logic      vld_q, vld_d;
  cfot_req_t req_q;
  logic      take;

  assign ready_o = !vld_q || adv_i;
  assign take    = valid_i && ready_o;
  assign vld_d   = take || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
    end
  end

  assign valid_o = vld_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/core/cfot_table.sv =====
// ----------------------------------------------------------------------------
// cfot_table
// Associative entry store: key compare, entry pick, change detect, update.
// ----------------------------------------------------------------------------
module cfot_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  cfot_pkg::cfot_req_t req_i,
  output cfot_pkg::cfot_rsp_t rsp_o
);
  import cfot_pkg::*;

  logic [KeyW-1:0]    key_q   [Entries];
  logic [Entries-1:0] found_q;
  logic [Entries-1:0] occ_q, occ_d;
  logic [Entries-1:0] sval_q, sval_d;
  cfot_snap_t         words_q [Entries];
  logic [FlagW-1:0]   flags_q [Entries];
  logic [IdxW-1:0]    cursor_q, cursor_d;

  logic [Entries-1:0] hit_vec;
  logic [Entries-1:0] free_vec;
  logic [IdxW-1:0]    hit_idx;
  logic [IdxW-1:0]    free_idx;
  logic [IdxW-1:0]    pick;
  cfot_kind_e         kind;
  cfot_snap_t         new_words;
  logic               lookup_chg;
  logic               snap_chg;
  logic [IdxW+SlotW-1:0] slot_ext;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      hit_vec[i]  = occ_q[i] && (key_q[i] == req_i.token);
      free_vec[i] = !occ_q[i];
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
      if (free_vec[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    if (|hit_vec) begin
      pick = hit_idx;
      kind = KindHit;
    end else if (|free_vec) begin
      pick = free_idx;
      kind = KindFree;
    end else begin
      pick = cursor_q;
      kind = KindReplace;
    end
  end

  assign new_words = {req_i.snap_word3, req_i.snap_word2, req_i.snap_word1, req_i.snap_word0};

  assign lookup_chg = !occ_q[pick] || (key_q[pick] != req_i.token)
                      || (found_q[pick] != req_i.found);
  assign snap_chg   = req_i.snapshot_valid
                      && (!sval_q[pick] || (flags_q[pick] != req_i.snap_flags)
                          || (words_q[pick] != new_words));

  always_comb begin
    occ_d    = occ_q;
    sval_d   = sval_q;
    cursor_d = cursor_q;
    if (adv_i) begin
      if (lookup_chg) begin
        occ_d[pick] = 1'b1;
      end
      sval_d[pick] = req_i.snapshot_valid;
      if (kind == KindReplace) begin
        cursor_d = (cursor_q == IdxW'(Entries - 1)) ? '0 : cursor_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      sval_q   <= '0;
      cursor_q <= '0;
    end else begin
      occ_q    <= occ_d;
      sval_q   <= sval_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && lookup_chg) begin
      key_q[pick]   <= req_i.token;
      found_q[pick] <= req_i.found;
    end
    if (adv_i && snap_chg) begin
      words_q[pick] <= new_words;
      flags_q[pick] <= req_i.snap_flags;
    end
  end

  assign slot_ext = {{SlotW{1'b0}}, pick};

  assign rsp_o.report_lookup = lookup_chg;
  assign rsp_o.report_state  = snap_chg;
  assign rsp_o.slot          = slot_ext[SlotW-1:0];
  assign rsp_o.slot_kind     = kind;

endmodule

// ===== rtl/core/cfot_out_stage.sv =====
// ----------------------------------------------------------------------------
// cfot_out_stage
// Result register toward the consumer.
// ----------------------------------------------------------------------------
module cfot_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  cfot_pkg::cfot_rsp_t rsp_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output cfot_pkg::cfot_rsp_t rsp_o
);
  import cfot_pkg::*;

  logic      vld_q, vld_d;
  cfot_rsp_t rsp_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = vld_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/core/cfot_checker.sv =====
// ----------------------------------------------------------------------------
// cfot_checker
// Port-level checks for the observation table, bound to the top level.
// ----------------------------------------------------------------------------
module cfot_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_lookup_i,
  input logic                       rsp_state_i,
  input logic [cfot_pkg::SlotW-1:0] rsp_slot_i,
  input cfot_pkg::cfot_kind_e       rsp_kind_i
);
  import cfot_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_lookup_i)
      && $stable(rsp_state_i) && $stable(rsp_slot_i) && $stable(rsp_kind_i))
    else $error("result changed while stalled");

  a_new_entry_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i != KindHit) |-> rsp_lookup_i)
    else $error("free or replaced entry without lookup report");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request stalled without a stalled result");

endmodule

bind change_filtered_observation_table_top cfot_checker u_cfot_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_lookup_i (rsp_o.report_lookup),
  .rsp_state_i  (rsp_o.report_state),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_kind_i   (rsp_o.slot_kind)
);
